>>> design/modexp_pkg.sv
package modexp_pkg;

    // sequencer states of the exponentiation engine
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } state_t;

endpackage

>>> design/modular_exponentiation.sv
// modular exponentiation, left-to-right binary method: each input beat carries
// base, exponent and modulus, and one output beat returns base^exponent mod
// modulus. a modulus below two gives 0, and a zero exponent gives 1. the block
// takes one beat at a time: s_tready is high only while the engine is idle.
// all arithmetic runs through one shared modular double-and-add unit, one
// multiplier bit per cycle. an item is loaded, the base is reduced by the
// modulus, then for each of the OPERAND_BITS exponent bits the running power
// is squared and, when the bit is set, multiplied by the base, and the result
// is handed over. a modulus below two skips all of this. the result sits in
// an output register, so the engine can start the next beat while it waits.
module modular_exponentiation #(
    parameter int OPERAND_BITS = 31
) (
    input  logic aclk,
    input  logic aresetn,
    // base, exponent, modulus from the lowest bit up, zero padded to bytes
    input  logic [8*((3*OPERAND_BITS+7)/8)-1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // power_mod, zero padded to bytes
    output logic [8*((OPERAND_BITS+7)/8)-1:0] m_tdata,
    output logic m_tvalid,
    input  logic m_tready
);

    localparam int W     = OPERAND_BITS;
    localparam int CW    = $clog2(W);
    localparam int OUT_W = 8*((W+7)/8);

    // input fields
    logic [W-1:0] in_base;
    logic [W-1:0] in_exp;
    logic [W-1:0] in_mod;

    assign in_base = s_tdata[W-1:0];
    assign in_exp  = s_tdata[2*W-1:W];
    assign in_mod  = s_tdata[3*W-1:2*W];

    modexp_pkg::state_t state_reg, state_next;

    logic [W-1:0]  base_reg,   base_next;    // base reduced by the modulus
    logic [W-1:0]  exp_reg,    exp_next;     // exponent, consumed from the msb
    logic [W-1:0]  mod_reg,    mod_next;
    logic [W-1:0]  acc_reg,    acc_next;     // running power
    logic [W-1:0]  prod_reg,   prod_next;    // partial product of the shared unit
    logic [W-1:0]  mcand_reg,  mcand_next;   // multiplicand
    logic [W-1:0]  mplier_reg, mplier_next;  // multiplier, consumed from the msb
    logic [CW-1:0] step_reg,   step_next;    // multiplier bit index
    logic [CW-1:0] bit_reg,    bit_next;     // exponent bit index
    logic [W-1:0]  out_reg,    out_next;
    logic          mvalid_reg, mvalid_next;

    logic last_step;
    logic last_bit;
    logic out_free;

    assign last_step = (step_reg == '0);
    assign last_bit  = (bit_reg == '0);
    assign out_free  = !mvalid_reg || m_tready;

    // shared unit: ((2*prod + cin) mod m + addend) mod m, with prod, addend < m
    logic         unit_cin;
    logic [W-1:0] unit_addend;
    logic [W:0]   dbl_sum;
    logic [W-1:0] dbl_red;
    logic [W:0]   add_sum;
    logic [W-1:0] unit_out;

    assign unit_cin    = (state_reg == modexp_pkg::ST_REDUCE) && mplier_reg[W-1];
    assign unit_addend = (state_reg != modexp_pkg::ST_REDUCE && mplier_reg[W-1])
                         ? mcand_reg : '0;

    always_comb begin
        dbl_sum = {prod_reg, unit_cin};
        if (dbl_sum >= {1'b0, mod_reg}) begin
            dbl_red = W'(dbl_sum - {1'b0, mod_reg});
        end else begin
            dbl_red = dbl_sum[W-1:0];
        end
        add_sum = {1'b0, dbl_red} + {1'b0, unit_addend};
        if (add_sum >= {1'b0, mod_reg}) begin
            unit_out = W'(add_sum - {1'b0, mod_reg});
        end else begin
            unit_out = add_sum[W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    // modulus below two needs no work, the result is zero
                    state_next = (in_mod < W'(2)) ? modexp_pkg::ST_DONE
                                                   : modexp_pkg::ST_REDUCE;
                end
            end
            modexp_pkg::ST_REDUCE: begin
                if (last_step) begin
                    state_next = modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_SQUARE: begin
                if (last_step) begin
                    if (exp_reg[W-1]) begin
                        state_next = modexp_pkg::ST_MULT;
                    end else if (last_bit) begin
                        state_next = modexp_pkg::ST_DONE;
                    end
                end
            end
            modexp_pkg::ST_MULT: begin
                if (last_step) begin
                    state_next = last_bit ? modexp_pkg::ST_DONE
                                          : modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = modexp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        base_next   = base_reg;
        exp_next    = exp_reg;
        mod_next    = mod_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        step_next   = step_reg;
        bit_next    = bit_reg;
        out_next    = out_reg;
        mvalid_next = mvalid_reg && !m_tready;
        s_tready    = 1'b0;

        case (state_reg)
            modexp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mod_next    = in_mod;
                    exp_next    = in_exp;
                    mplier_next = in_base;   // shifted in to reduce the base
                    prod_next   = '0;
                    acc_next    = (in_mod < W'(2)) ? '0 : W'(1);
                    step_next   = CW'(W-1);
                    bit_next    = CW'(W-1);
                end
            end
            modexp_pkg::ST_REDUCE: begin
                prod_next   = unit_out;
                mplier_next = mplier_reg << 1;
                step_next   = step_reg - 1'b1;
                if (last_step) begin
                    // base done, set up the first square of acc = 1
                    base_next   = unit_out;
                    prod_next   = '0;
                    mcand_next  = acc_reg;
                    mplier_next = acc_reg;
                    step_next   = CW'(W-1);
                end
            end
            modexp_pkg::ST_SQUARE: begin
                prod_next   = unit_out;
                mplier_next = mplier_reg << 1;
                step_next   = step_reg - 1'b1;
                if (last_step) begin
                    acc_next  = unit_out;
                    prod_next = '0;
                    step_next = CW'(W-1);
                    if (exp_reg[W-1]) begin
                        // bit set: multiply by the base next
                        mcand_next  = unit_out;
                        mplier_next = base_reg;
                    end else begin
                        mcand_next  = unit_out;
                        mplier_next = unit_out;
                        exp_next    = exp_reg << 1;
                        bit_next    = bit_reg - 1'b1;
                    end
                end
            end
            modexp_pkg::ST_MULT: begin
                prod_next   = unit_out;
                mplier_next = mplier_reg << 1;
                step_next   = step_reg - 1'b1;
                if (last_step) begin
                    acc_next    = unit_out;
                    prod_next   = '0;
                    step_next   = CW'(W-1);
                    mcand_next  = unit_out;
                    mplier_next = unit_out;
                    exp_next    = exp_reg << 1;
                    bit_next    = bit_reg - 1'b1;
                end
            end
            modexp_pkg::ST_DONE: begin
                if (out_free) begin
                    out_next    = acc_reg;
                    mvalid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= modexp_pkg::ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        mod_reg    <= mod_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        step_reg   <= step_next;
        bit_reg    <= bit_next;
        out_reg    <= out_next;
    end

    assign m_tdata  = OUT_W'(out_reg);
    assign m_tvalid = mvalid_reg;

endmodule
